### rtl/ccl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccl_pkg
// Shared constants, codes and control types of the connected component labeler.
// ----------------------------------------------------------------------------
package ccl_pkg;

   // field widths and defaults
   localparam int MAX_VERTICES_DEF = 64;
   localparam int VERTEX_W         = 6;
   localparam int COUNT_W          = 7;
   localparam int FUNC_W           = 2;

   localparam logic [COUNT_W-1:0] VERTEX_COUNT_RST = 7'd64;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_RUN   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADD_RD_A,
      ST_ADD_WR_A,
      ST_ADD_RD_B,
      ST_ADD_WR_B,
      ST_FIND_ROOT,
      ST_POP,
      ST_ROW_RD,
      ST_ROW_LOAD,
      ST_PUSH,
      ST_EMIT
   } ccl_state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic clear_adj;
      logic edge_rd;
      logic edge_wr;
      logic edge_sel_b;
      logic run_init;
      logic take_root;
      logic pop;
      logic row_rd;
      logic row_load;
      logic push;
      logic emit_init;
      logic emit;
   } ccl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic edge_ok;
      logic root_found;
      logic stack_empty;
      logic pending_any;
      logic emit_last;
   } ccl_status_type;

endpackage

### rtl/ccl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccl_ctrl
// Sequencer for edge insert, clear, depth-first labeling and result emission.
// ----------------------------------------------------------------------------
module ccl_ctrl import ccl_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [FUNC_W-1:0]   req_func,
   input  ccl_status_type      status,
   output logic                busy,
   output ccl_cmd_type         cmd
);

   ccl_state_type state_ff;
   ccl_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_func)
                  FUNC_ADD: begin
                     if (status.edge_ok) state_in = ST_ADD_RD_A;
                  end
                  FUNC_RUN: state_in = ST_FIND_ROOT;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_ADD_RD_A: state_in = ST_ADD_WR_A;
         ST_ADD_WR_A: state_in = ST_ADD_RD_B;
         ST_ADD_RD_B: state_in = ST_ADD_WR_B;
         ST_ADD_WR_B: state_in = ST_IDLE;
         ST_FIND_ROOT: begin
            if (status.root_found) state_in = ST_POP;
            else                   state_in = ST_EMIT;
         end
         ST_POP: begin
            if (status.stack_empty) state_in = ST_FIND_ROOT;
            else                    state_in = ST_ROW_RD;
         end
         ST_ROW_RD:   state_in = ST_ROW_LOAD;
         ST_ROW_LOAD: state_in = ST_PUSH;
         ST_PUSH: begin
            if (!status.pending_any) state_in = ST_POP;
         end
         ST_EMIT: begin
            if (status.emit_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd  = '0;
      busy = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               case (req_func)
                  FUNC_RUN:   cmd.run_init  = 1'b1;
                  FUNC_CLEAR: cmd.clear_adj = 1'b1;
                  default:    cmd.capture   = 1'b1;
               endcase
            end
         end
         ST_ADD_RD_A: cmd.edge_rd = 1'b1;
         ST_ADD_WR_A: cmd.edge_wr = 1'b1;
         ST_ADD_RD_B: begin
            cmd.edge_rd    = 1'b1;
            cmd.edge_sel_b = 1'b1;
         end
         ST_ADD_WR_B: begin
            cmd.edge_wr    = 1'b1;
            cmd.edge_sel_b = 1'b1;
         end
         ST_FIND_ROOT: begin
            if (status.root_found) cmd.take_root = 1'b1;
            else                   cmd.emit_init = 1'b1;
         end
         ST_POP: begin
            if (!status.stack_empty) cmd.pop = 1'b1;
         end
         ST_ROW_RD:   cmd.row_rd   = 1'b1;
         ST_ROW_LOAD: cmd.row_load = 1'b1;
         ST_PUSH: begin
            if (status.pending_any) cmd.push = 1'b1;
         end
         ST_EMIT: cmd.emit = 1'b1;
         default: cmd = '0;
      endcase
   end

endmodule

### rtl/ccl_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccl_datapath
// Adjacency, label and stack memories, visited and pending vectors, counters
// and the result register.
// ----------------------------------------------------------------------------
module ccl_datapath import ccl_pkg::*; #(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [COUNT_W-1:0]  csr_wr_data,
   input  logic [VERTEX_W-1:0] req_vertex_a,
   input  logic [VERTEX_W-1:0] req_vertex_b,
   input  ccl_cmd_type         cmd,
   output ccl_status_type      status,
   output logic                rsp_strobe,
   output logic [VERTEX_W-1:0] rsp_vertex,
   output logic [VERTEX_W-1:0] rsp_label,
   output logic                rsp_last
);

   localparam int IDX_W   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int DEPTH_W = $clog2(MAX_VERTICES + 1);
   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_VERTICES);

   typedef logic [MAX_VERTICES-1:0] row_type;

   // memories
   row_type          adj_mem   [MAX_VERTICES];
   logic [IDX_W-1:0] label_mem [MAX_VERTICES];
   logic [IDX_W-1:0] stack_mem [MAX_VERTICES];

   logic [COUNT_W-1:0] vertex_count_ff;
   logic [COUNT_W-1:0] n_eff;
   row_type            in_use;
   row_type            adj_valid_ff;
   row_type            adj_rd_ff;
   logic               adj_rd_vld_ff;
   row_type            adj_row;
   logic [IDX_W-1:0]   a_ff;
   logic [IDX_W-1:0]   b_ff;
   logic [IDX_W-1:0]   edge_row;
   logic [IDX_W-1:0]   edge_col;
   row_type            edge_bit;
   logic [IDX_W-1:0]   adj_rd_addr;
   row_type            visited_ff;
   row_type            visited_in;
   row_type            pending_ff;
   row_type            pending_in;
   row_type            row_new;
   row_type            candidates;
   logic [IDX_W-1:0]   root_idx;
   logic [IDX_W-1:0]   push_idx;
   logic [IDX_W-1:0]   root_ff;
   logic [DEPTH_W-1:0] depth_ff;
   logic [DEPTH_W-1:0] depth_in;
   logic [DEPTH_W-1:0] depth_dec;
   logic [IDX_W-1:0]   stack_rd_ff;
   logic [IDX_W-1:0]   emit_cnt_ff;
   logic               strobe_ff;
   logic [IDX_W-1:0]   emit_vtx_ff;
   logic [IDX_W-1:0]   label_rd_ff;
   logic               last_ff;

   // lowest set bit of a vertex vector
   function automatic logic [IDX_W-1:0] lowest_set(input row_type v);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
         if (v[i]) idx = IDX_W'(i);
      end
      return idx;
   endfunction

   // vertex count register
   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= VERTEX_COUNT_RST;
      end else if (csr_wr_en) begin
         vertex_count_ff <= csr_wr_data;
      end
   end

   // effective count, clamped to 1..MAX_VERTICES
   always_comb begin
      n_eff = vertex_count_ff;
      if (vertex_count_ff == '0)           n_eff = COUNT_W'(1);
      else if (vertex_count_ff > MAX_COUNT) n_eff = MAX_COUNT;
   end

   // mask of vertices in use
   always_comb begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
         in_use[i] = (COUNT_W'(i) < n_eff);
      end
   end

   // endpoint capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         a_ff <= req_vertex_a[IDX_W-1:0];
         b_ff <= req_vertex_b[IDX_W-1:0];
      end
   end

   // edge row and column selection
   always_comb begin
      edge_row = cmd.edge_sel_b ? b_ff : a_ff;
      edge_col = cmd.edge_sel_b ? a_ff : b_ff;
      edge_bit = '0;
      edge_bit[edge_col] = 1'b1;
      adj_rd_addr = cmd.row_rd ? stack_rd_ff : edge_row;
      adj_row = adj_rd_vld_ff ? adj_rd_ff : '0;
   end

   // adjacency memory, registered read
   always_ff @(posedge clock) begin
      if (cmd.edge_rd || cmd.row_rd) begin
         adj_rd_ff     <= adj_mem[adj_rd_addr];
         adj_rd_vld_ff <= adj_valid_ff[adj_rd_addr];
      end
      if (cmd.edge_wr) begin
         adj_mem[edge_row] <= adj_row | edge_bit;
      end
   end

   // row valid bits, an invalid row reads as no edges
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_adj) begin
         adj_valid_ff <= '0;
      end else if (cmd.edge_wr) begin
         adj_valid_ff[edge_row] <= 1'b1;
      end
   end

   // walk selection
   always_comb begin
      candidates = in_use & ~visited_ff;
      root_idx   = lowest_set(candidates);
      push_idx   = lowest_set(pending_ff);
      row_new    = adj_row & in_use & ~visited_ff;
      depth_dec  = depth_ff - 1'b1;
   end

   // visited, pending and stack depth next values
   always_comb begin
      visited_in = visited_ff;
      pending_in = pending_ff;
      depth_in   = depth_ff;
      if (cmd.run_init) begin
         visited_in = '0;
         pending_in = '0;
         depth_in   = '0;
      end
      if (cmd.take_root) begin
         visited_in[root_idx] = 1'b1;
         depth_in = depth_ff + 1'b1;
      end
      if (cmd.pop) begin
         depth_in = depth_dec;
      end
      if (cmd.row_load) begin
         visited_in = visited_ff | row_new;
         pending_in = row_new;
      end
      if (cmd.push) begin
         pending_in[push_idx] = 1'b0;
         depth_in = depth_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         visited_ff <= '0;
         pending_ff <= '0;
         depth_ff   <= '0;
      end else begin
         visited_ff <= visited_in;
         pending_ff <= pending_in;
         depth_ff   <= depth_in;
      end
   end

   // current root
   always_ff @(posedge clock) begin
      if (cmd.take_root) begin
         root_ff <= root_idx;
      end
   end

   // label and stack memories
   always_ff @(posedge clock) begin
      if (cmd.take_root) begin
         label_mem[root_idx] <= root_idx;
         stack_mem[depth_ff[IDX_W-1:0]] <= root_idx;
      end else if (cmd.push) begin
         label_mem[push_idx] <= root_ff;
         stack_mem[depth_ff[IDX_W-1:0]] <= push_idx;
      end
      if (cmd.pop) begin
         stack_rd_ff <= stack_mem[depth_dec[IDX_W-1:0]];
      end
   end

   // emit counter
   always_ff @(posedge clock) begin
      if (reset || cmd.emit_init) begin
         emit_cnt_ff <= '0;
      end else if (cmd.emit) begin
         emit_cnt_ff <= emit_cnt_ff + 1'b1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         label_rd_ff <= label_mem[emit_cnt_ff];
         emit_vtx_ff <= emit_cnt_ff;
         last_ff     <= status.emit_last;
      end
   end

   // status to controller
   always_comb begin
      status.edge_ok     = (COUNT_W'(req_vertex_a) < n_eff) &&
                           (COUNT_W'(req_vertex_b) < n_eff);
      status.root_found  = |candidates;
      status.stack_empty = (depth_ff == '0);
      status.pending_any = |pending_ff;
      status.emit_last   = (COUNT_W'(emit_cnt_ff) == (n_eff - 1'b1));
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_vertex = VERTEX_W'(emit_vtx_ff);
   assign rsp_label  = VERTEX_W'(label_rd_ff);
   assign rsp_last   = last_ff;

endmodule

### rtl/connected_component_labeler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// connected_component_labeler
// Undirected graph store with depth-first connected component labeling.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. An add-edge
// transaction does a read-modify-write of both adjacency rows on one port;
// one with an endpoint at or beyond the vertex count is dropped, and a
// clear is done, without leaving idle. A run walks the graph with an
// explicit stack: it takes a root per component, then for each vertex
// popped reads and loads its adjacency row and pushes unvisited neighbours
// one at a time; the stack and adjacency memories each have a single read
// port. It then puts out one result per vertex in use, one per cycle in
// vertex order, each on the rsp_ ports for a single cycle under rsp_strobe;
// the receiver cannot stall them. busy falls as the last one appears.
// Write csr_wr_data only while busy is low and no result is pending.
// ----------------------------------------------------------------------------
module connected_component_labeler import ccl_pkg::*; #(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [COUNT_W-1:0]  csr_wr_data,
   input  logic                start,
   output logic                busy,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [VERTEX_W-1:0] req_vertex_a,
   input  logic [VERTEX_W-1:0] req_vertex_b,
   output logic                rsp_strobe,
   output logic [VERTEX_W-1:0] rsp_vertex,
   output logic [VERTEX_W-1:0] rsp_label,
   output logic                rsp_last
);

   ccl_cmd_type    cmd;
   ccl_status_type status;

   // sequencer
   ccl_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_func),
      .status   (status),
      .busy     (busy),
      .cmd      (cmd)
   );

   // storage and arithmetic
   ccl_datapath #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_vertex_a (req_vertex_a),
      .req_vertex_b (req_vertex_b),
      .cmd          (cmd),
      .status       (status),
      .rsp_strobe   (rsp_strobe),
      .rsp_vertex   (rsp_vertex),
      .rsp_label    (rsp_label),
      .rsp_last     (rsp_last)
   );

endmodule
